// File: src/assert_macros.svh
// Assertion macros used by the list engine datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed: implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/olist_pkg.sv
// Shared codes and controller/datapath interface types for the ordered list engine.
`default_nettype none

package olist_pkg;

  // Command codes carried in the request.
  localparam logic [2:0] MODE_INS_FRONT = 3'd0;
  localparam logic [2:0] MODE_INS_END   = 3'd1;
  localparam logic [2:0] MODE_INS_POS   = 3'd2;
  localparam logic [2:0] MODE_DEL_FIRST = 3'd3;
  localparam logic [2:0] MODE_DEL_LAST  = 3'd4;
  localparam logic [2:0] MODE_DEL_POS   = 3'd5;
  localparam logic [2:0] MODE_SEARCH    = 3'd6;
  localparam logic [2:0] MODE_READ_OUT  = 3'd7;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_BAD_POS   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // Pointer operations.
  localparam logic [1:0] PTR_HOLD        = 2'd0;
  localparam logic [1:0] PTR_LOAD_COUNT  = 2'd1;
  localparam logic [1:0] PTR_LOAD_TARGET = 2'd2;
  localparam logic [1:0] PTR_STEP        = 2'd3;

  // Read address selection relative to the pointer.
  localparam logic [1:0] RD_AT   = 2'd0;
  localparam logic [1:0] RD_PREV = 2'd1;
  localparam logic [1:0] RD_NEXT = 2'd2;

  // Longest run of results a read out produces.
  localparam int RUN_LIMIT = 16;

  typedef struct packed {
    logic       capture;
    logic [1:0] ptr_op;
    logic       ptr_down;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic       wr_item;
    logic       res_cap;
    logic       count_inc;
    logic       count_dec;
    logic       out_load;
    logic       out_run;
    logic [2:0] out_status;
  } olist_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       full;
    logic       empty;
    logic       pos_bad;
    logic       at_target;
    logic       ptr_last;
    logic       run_last;
    logic       match;
    logic       out_free;
  } olist_stat_t;

endpackage

`default_nettype wire

// File: src/olist_dp.sv
// Datapath of the ordered list engine: item memory, pointer, count and result register.
`default_nettype none
`include "assert_macros.svh"

module olist_dp import olist_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [39:0] s_tdata,
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,
  output logic [2:0]       m_tuser,
  output logic             m_tlast,
  input  wire olist_cmd_t  cmd,
  output olist_stat_t      stat
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((CNT_W > 5) ? CNT_W : 5) + 1;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] item;
  logic [2:0]            mode;
  logic [4:0]            pos;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      ptr;
  logic [31:0]           res_val;
  logic [4:0]            res_pos;
  logic [31:0]           out_val;
  logic [4:0]            out_pos;
  logic [4:0]            out_len;
  logic [2:0]            out_status;

  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] ptr_w;
  logic [CMP_W-1:0] ptr_inc;
  logic [CMP_W-1:0] target_w;
  logic [CMP_W-1:0] run_n;
  logic [CMP_W-1:0] raddr_w;
  logic [CNT_W-1:0] target;
  logic             out_free;
  logic             run_last;

  assign cnt_w   = CMP_W'(count);
  assign pos_w   = CMP_W'(pos);
  assign ptr_w   = CMP_W'(ptr);
  assign ptr_inc = ptr_w + 1'b1;
  assign run_n   = (cnt_w < CMP_W'(RUN_LIMIT)) ? cnt_w : CMP_W'(RUN_LIMIT);

  // Index of the target entry: where a delete, search or read out starts and where an insert places its item.
  always_comb begin
    case (mode)
      MODE_INS_END:                target_w = cnt_w;
      MODE_DEL_LAST:               target_w = cnt_w - 1'b1;
      MODE_INS_POS, MODE_DEL_POS:  target_w = pos_w - 1'b1;
      default:                     target_w = '0;
    endcase
  end
  assign target = CNT_W'(target_w);

  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: raddr_w = ptr_w - 1'b1;
      RD_NEXT: raddr_w = ptr_inc;
      default: raddr_w = ptr_w;
    endcase
  end

  assign out_free = !m_tvalid || m_tready;
  assign run_last = ptr_inc >= run_n;

  always_comb begin
    stat.mode      = mode;
    stat.full      = count == CNT_W'(CAPACITY);
    stat.empty     = count == '0;
    stat.pos_bad   = (pos == 5'd0) ||
                     (pos_w > ((mode == MODE_INS_POS) ? cnt_w + 1'b1 : cnt_w));
    stat.at_target = ptr == target;
    stat.ptr_last  = ptr_inc >= cnt_w;
    stat.run_last  = run_last;
    stat.match     = rdata == item;
    stat.out_free  = out_free;
  end

  // Item memory: at most one write and one registered read per cycle, each on its own enable.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[ptr[ADDR_W-1:0]] <= cmd.wr_item ? item : rdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr_w[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode    <= s_tuser;
      pos     <= s_tdata[4:0];
      item    <= DATA_WIDTH'($signed(s_tdata[36:5]));
      res_val <= '0;
      res_pos <= '0;
    end else if (cmd.res_cap) begin
      res_val <= 32'(rdata);
      res_pos <= ptr_inc[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
    end else begin
      if (cmd.count_inc) begin
        count <= count + 1'b1;
      end else if (cmd.count_dec) begin
        count <= count - 1'b1;
      end
      case (cmd.ptr_op)
        PTR_LOAD_COUNT:  ptr <= count;
        PTR_LOAD_TARGET: ptr <= target;
        PTR_STEP:        ptr <= cmd.ptr_down ? ptr - 1'b1 : ptr + 1'b1;
        default:         ptr <= ptr;
      endcase
    end
  end

  // Output register; a new result loads only when the old one has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_val    <= res_val;
      out_pos    <= res_pos;
      out_len    <= 5'(count);
      out_status <= cmd.out_status;
      m_tlast    <= cmd.out_run ? run_last : 1'b1;
    end
  end

  assign m_tdata = {6'd0, out_len, out_pos, out_val};
  assign m_tuser = out_status;

  `ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.out_load, out_free)
  `ASSERT_IMPLY(a_no_grow_when_full, clk, rst, cmd.count_inc, count < CNT_W'(CAPACITY))
  `ASSERT_IMPLY(a_read_in_list, clk, rst, cmd.rd_en && (cmd.rd_sel != RD_PREV),
                raddr_w < cnt_w)
  `ASSERT_NEXT(a_shrink_by_one, clk, rst, cmd.count_dec, count == $past(count) - 1'b1)

endmodule

`default_nettype wire

// File: src/olist_ctrl.sv
// Controller state machine of the ordered list engine.
`default_nettype none

module olist_ctrl import olist_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire olist_stat_t stat,
  output olist_cmd_t       cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DECODE  = 5'd1;
  localparam logic [4:0] S_UP_CHK  = 5'd2;
  localparam logic [4:0] S_UP_RD   = 5'd3;
  localparam logic [4:0] S_UP_WR   = 5'd4;
  localparam logic [4:0] S_PUT_NEW = 5'd5;
  localparam logic [4:0] S_DEL_RD  = 5'd6;
  localparam logic [4:0] S_DEL_CAP = 5'd7;
  localparam logic [4:0] S_DN_CHK  = 5'd8;
  localparam logic [4:0] S_DN_RD   = 5'd9;
  localparam logic [4:0] S_DN_WR   = 5'd10;
  localparam logic [4:0] S_SR_RD   = 5'd11;
  localparam logic [4:0] S_SR_CMP  = 5'd12;
  localparam logic [4:0] S_RO_RD   = 5'd13;
  localparam logic [4:0] S_RO_CAP  = 5'd14;
  localparam logic [4:0] S_RO_EMIT = 5'd15;
  localparam logic [4:0] S_FINISH  = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [2:0] code;
  logic [2:0] code_next;

  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        case (stat.mode)
          MODE_INS_FRONT, MODE_INS_END, MODE_INS_POS: begin
            if (stat.full) begin
              code_next = ST_FULL;
            end else if (stat.mode == MODE_INS_POS && stat.pos_bad) begin
              code_next = ST_BAD_POS;
            end else begin
              cmd.ptr_op = PTR_LOAD_COUNT;
              state_next = S_UP_CHK;
            end
          end
          MODE_DEL_FIRST, MODE_DEL_LAST, MODE_DEL_POS: begin
            if (stat.empty) begin
              code_next = ST_EMPTY;
            end else if (stat.mode == MODE_DEL_POS && stat.pos_bad) begin
              code_next = ST_BAD_POS;
            end else begin
              cmd.ptr_op = PTR_LOAD_TARGET;
              state_next = S_DEL_RD;
            end
          end
          MODE_SEARCH: begin
            if (stat.empty) begin
              code_next = ST_EMPTY;
            end else begin
              cmd.ptr_op = PTR_LOAD_TARGET;
              state_next = S_SR_RD;
            end
          end
          default: begin
            if (stat.empty) begin
              code_next = ST_EMPTY;
            end else begin
              cmd.ptr_op = PTR_LOAD_TARGET;
              state_next = S_RO_RD;
            end
          end
        endcase
      end
      // Insert: move entries up one place from the tail down to the target.
      S_UP_CHK: begin
        state_next = stat.at_target ? S_PUT_NEW : S_UP_RD;
      end
      S_UP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PREV;
        state_next = S_UP_WR;
      end
      S_UP_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.ptr_op   = PTR_STEP;
        cmd.ptr_down = 1'b1;
        state_next   = S_UP_CHK;
      end
      S_PUT_NEW: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_item   = 1'b1;
        cmd.count_inc = 1'b1;
        code_next     = ST_OK;
        state_next    = S_FINISH;
      end
      // Delete: take the target entry, then move the rest down one place.
      S_DEL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_AT;
        state_next = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        cmd.res_cap = 1'b1;
        state_next  = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (stat.ptr_last) begin
          cmd.count_dec = 1'b1;
          code_next     = ST_OK;
          state_next    = S_FINISH;
        end else begin
          state_next = S_DN_RD;
        end
      end
      S_DN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_NEXT;
        state_next = S_DN_WR;
      end
      S_DN_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.ptr_op = PTR_STEP;
        state_next = S_DN_CHK;
      end
      S_SR_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_AT;
        state_next = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (stat.match) begin
          cmd.res_cap = 1'b1;
          code_next   = ST_OK;
          state_next  = S_FINISH;
        end else if (stat.ptr_last) begin
          code_next  = ST_NOT_FOUND;
          state_next = S_FINISH;
        end else begin
          cmd.ptr_op = PTR_STEP;
          state_next = S_SR_RD;
        end
      end
      S_RO_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_AT;
        state_next = S_RO_CAP;
      end
      S_RO_CAP: begin
        cmd.res_cap = 1'b1;
        state_next  = S_RO_EMIT;
      end
      S_RO_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_run    = 1'b1;
          cmd.out_status = ST_OK;
          if (stat.run_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.ptr_op = PTR_STEP;
            state_next = S_RO_RD;
          end
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = code;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule

`default_nettype wire

// File: src/ordered_list_engine_unit.sv
// Top level of the ordered list engine: controller plus datapath.
//
//   channel  direction  handshake          payload
//   s_*      in         tvalid / tready    tuser: mode; tdata: position, value
//   m_*      out        tvalid / tready    tuser: status; tdata: value, position, length
//
// Each command walks the list one entry at a time over one memory port: insert moves
// entries up from the tail, delete moves the entries after the target down, search
// probes from the head and read out emits the entries from the head in order.
// Reset is synchronous and active high; it empties the list and drops any result.
// A result waits in the output register; when it is not taken the engine stalls at
// its next result and does not take a new request before the last result is loaded.
`default_nettype none

module ordered_list_engine_unit import olist_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // position[4:0], value[36:5], zero pad
  input  wire logic [2:0]  s_tuser,   // mode[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // item_value[31:0], item_position[36:32],
                                      // list_length[41:37], zero pad
  output logic [2:0]       m_tuser,   // status[2:0]
  output logic             m_tlast
);

  olist_cmd_t  cmd;
  olist_stat_t stat;

  olist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  olist_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire

// File: verif/ordered_list_checker.sv
// Checker for the ordered list engine: mirrors the list, predicts and compares every result.
`timescale 1ns / 100ps

module ordered_list_checker import olist_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // position[4:0], value[36:5], zero pad
  input  logic [2:0]  s_tuser,   // mode[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // item_value[31:0], item_position[36:32],
                                 // list_length[41:37], zero pad
  input  logic [2:0]  m_tuser,   // status[2:0]
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending,
  output logic [4:0]  list_len
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic [4:0]  position;
    logic [4:0]  length;
    logic        last;
  } list_result_t;

  logic [31:0]  held_items[$];
  list_result_t expected_results[$];

  // The length field always reports the list as it stands after the request.
  function automatic list_result_t make_result(logic [2:0] status, logic [31:0] value,
                                               logic [4:0] position, logic last);
    make_result = '{status, value, position, 5'(held_items.size()), last};
  endfunction

  task automatic apply_list_command(input logic [2:0] mode, input logic [4:0] position,
                                    input logic [31:0] value);
    int          count;
    int          slot;
    int          run_len;
    int          k;
    logic [31:0] removed;
    count = held_items.size();
    case (mode)
      MODE_INS_FRONT, MODE_INS_END, MODE_INS_POS: begin
        if (count >= CAPACITY) begin
          expected_results.push_back(make_result(ST_FULL, '0, '0, 1'b1));
        end else if (mode == MODE_INS_POS &&
                     (int'(position) < 1 || int'(position) > count + 1)) begin
          expected_results.push_back(make_result(ST_BAD_POS, '0, '0, 1'b1));
        end else begin
          if (mode == MODE_INS_FRONT) slot = 0;
          else if (mode == MODE_INS_END) slot = count;
          else slot = int'(position) - 1;
          held_items.insert(slot, value);
          expected_results.push_back(make_result(ST_OK, '0, '0, 1'b1));
        end
      end
      MODE_DEL_FIRST, MODE_DEL_LAST, MODE_DEL_POS: begin
        if (count == 0) begin
          expected_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
        end else if (mode == MODE_DEL_POS &&
                     (int'(position) < 1 || int'(position) > count)) begin
          expected_results.push_back(make_result(ST_BAD_POS, '0, '0, 1'b1));
        end else begin
          if (mode == MODE_DEL_FIRST) slot = 0;
          else if (mode == MODE_DEL_LAST) slot = count - 1;
          else slot = int'(position) - 1;
          removed = held_items[slot];
          held_items.delete(slot);
          expected_results.push_back(make_result(ST_OK, removed, 5'(slot + 1), 1'b1));
        end
      end
      MODE_SEARCH: begin
        if (count == 0) begin
          expected_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          slot = -1;
          for (k = 0; k < count && slot < 0; k++)
            if (held_items[k] == value) slot = k;
          if (slot < 0)
            expected_results.push_back(make_result(ST_NOT_FOUND, '0, '0, 1'b1));
          else
            expected_results.push_back(make_result(ST_OK, held_items[slot],
                                                   5'(slot + 1), 1'b1));
        end
      end
      default: begin
        if (count == 0) begin
          expected_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          run_len = (count < RUN_LIMIT) ? count : RUN_LIMIT;
          for (k = 0; k < run_len; k++)
            expected_results.push_back(make_result(ST_OK, held_items[k], 5'(k + 1),
                                                   k + 1 == run_len));
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      held_items.delete();
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0h value %0h",
                   $time, m_tuser, m_tdata[31:0]);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, m_tuser);
          check_field("item_value", want.value, m_tdata[31:0]);
          check_field("item_position", want.position, m_tdata[36:32]);
          check_field("list_length", want.length, m_tdata[41:37]);
          check_field("last_of_run", want.last, m_tlast);
        end
      end
      // A result can never leave at the edge its own request is taken, so compare first.
      if (s_tvalid && s_tready)
        apply_list_command(s_tuser, s_tdata[4:0], s_tdata[36:5]);
    end
    pending = expected_results.size();
    list_len <= 5'(held_items.size());
  end

endmodule

// File: verif/tb_ordered_list_engine_unit.sv
// Testbench top for the ordered list engine: drives requests, paces results, gives the verdict.
`timescale 1ns / 100ps

module tb_ordered_list_engine_unit;
  import olist_pkg::*;

  localparam int CAPACITY        = 16;
  localparam int RANDOM_REQUESTS = 300;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 64;
  localparam int CYCLE_LIMIT     = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  int          fail_count;
  int          pending;
  logic [4:0]  list_len;
  logic        hold_go = 1'b0;
  logic        hold_sink = 1'b0;
  int          cycles = 0;
  logic [31:0] recent_values[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ordered_list_engine_unit #(.CAPACITY(CAPACITY), .DATA_WIDTH(32)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  ordered_list_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending), .list_len(list_len)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ordered_list_engine_unit regression: fail");
      $finish;
    end
  end

  // Long stall of the result side, so the engine backs up and refuses requests.
  initial begin : long_hold
    int held_for;
    @(posedge clk);
    while (!hold_go) @(posedge clk);
    hold_sink <= 1'b1;
    for (held_for = 0; held_for < HOLD_CYCLES; held_for++) @(posedge clk);
    hold_sink <= 1'b0;
  end

  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    @(posedge clk);
    forever begin
      gap = ((taken / 40) % 4 == 3) ? 0 : $urandom_range(0, 15);
      if (gap != 0 || hold_sink) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_sink) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  task automatic send_request(input logic [2:0] mode, input logic [4:0] position,
                              input logic [31:0] value, input bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {3'b000, value, position};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Mostly wide random values, with extremes and a few small ones so duplicates occur.
  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      case ($urandom_range(0, 3))
        0: pick_value = 32'h8000_0000;
        1: pick_value = 32'h7FFF_FFFF;
        2: pick_value = 32'h0000_0000;
        default: pick_value = 32'hFFFF_FFFF;
      endcase
    end else if (roll < 25) begin
      pick_value = 32'($urandom_range(0, 7));
    end else begin
      pick_value = $urandom;
    end
  endfunction

  task automatic random_request(input int idx);
    int          roll;
    int          len;
    logic [2:0]  mode;
    logic [4:0]  position;
    logic [31:0] value;
    roll = $urandom_range(0, 99);
    len = int'(list_len);
    // Phases lean toward filling, mixing, then draining, so both full and empty recur.
    case ((idx / 50) % 3)
      0: begin
        if (roll < 60) mode = 3'($urandom_range(MODE_INS_FRONT, MODE_INS_POS));
        else if (roll < 80) mode = 3'($urandom_range(MODE_DEL_FIRST, MODE_DEL_POS));
        else if (roll < 90) mode = MODE_SEARCH;
        else mode = MODE_READ_OUT;
      end
      1: begin
        if (roll < 35) mode = 3'($urandom_range(MODE_INS_FRONT, MODE_INS_POS));
        else if (roll < 65) mode = 3'($urandom_range(MODE_DEL_FIRST, MODE_DEL_POS));
        else if (roll < 88) mode = MODE_SEARCH;
        else mode = MODE_READ_OUT;
      end
      default: begin
        if (roll < 20) mode = 3'($urandom_range(MODE_INS_FRONT, MODE_INS_POS));
        else if (roll < 75) mode = 3'($urandom_range(MODE_DEL_FIRST, MODE_DEL_POS));
        else if (roll < 90) mode = MODE_SEARCH;
        else mode = MODE_READ_OUT;
      end
    endcase

    if ($urandom_range(0, 99) < 15)
      position = 5'($urandom_range(0, 31));
    else if (mode == MODE_DEL_POS)
      position = 5'($urandom_range(1, (len > 0) ? len : 1));
    else
      position = 5'($urandom_range(1, len + 1));

    if (mode == MODE_SEARCH && recent_values.size() != 0 && $urandom_range(0, 99) < 70)
      value = recent_values[$urandom_range(0, recent_values.size() - 1)];
    else
      value = pick_value();

    if (mode == MODE_INS_FRONT || mode == MODE_INS_END || mode == MODE_INS_POS) begin
      recent_values.push_back(value);
      if (recent_values.size() > 12) void'(recent_values.pop_front());
    end

    send_request(mode, position, value, (idx / 30) % 4 == 3);
  endtask

  initial begin : stimulus
    int idx;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Everything that can fail on an empty list.
    send_request(MODE_READ_OUT, 5'd0, '0, 1'b0);
    send_request(MODE_DEL_FIRST, 5'd0, '0, 1'b0);
    send_request(MODE_DEL_LAST, 5'd0, '0, 1'b0);
    send_request(MODE_DEL_POS, 5'd1, '0, 1'b0);
    send_request(MODE_SEARCH, 5'd0, '0, 1'b0);
    send_request(MODE_INS_POS, 5'd2, 32'h0000_0001, 1'b0);

    // Fill to capacity, starting with the extreme values.
    send_request(MODE_INS_POS, 5'd1, 32'h8000_0000, 1'b0);
    send_request(MODE_INS_FRONT, 5'd0, 32'h7FFF_FFFF, 1'b0);
    send_request(MODE_INS_END, 5'd0, 32'hFFFF_FFFF, 1'b0);
    send_request(MODE_INS_POS, 5'd4, 32'h0000_0000, 1'b0);
    for (idx = 0; idx < CAPACITY - 4; idx++)
      send_request(3'($urandom_range(MODE_INS_FRONT, MODE_INS_POS)),
                   5'($urandom_range(1, 5 + idx)), $urandom, 1'b0);

    send_request(MODE_INS_FRONT, 5'd0, 32'h0000_0002, 1'b0);
    send_request(MODE_INS_POS, 5'd1, 32'h0000_0003, 1'b0);
    send_request(MODE_READ_OUT, 5'd31, '0, 1'b0);
    send_request(MODE_SEARCH, 5'd0, 32'h8000_0000, 1'b0);
    send_request(MODE_SEARCH, 5'd0, 32'h1234_5678, 1'b0);
    send_request(MODE_DEL_POS, 5'd0, '0, 1'b0);
    send_request(MODE_DEL_POS, 5'd31, '0, 1'b0);
    send_request(MODE_DEL_POS, 5'd16, '0, 1'b0);
    send_request(MODE_DEL_LAST, 5'd0, '0, 1'b0);
    send_request(MODE_DEL_FIRST, 5'd0, '0, 1'b0);

    for (idx = 0; idx < RANDOM_REQUESTS; idx++) begin
      if (idx == 100) hold_go <= 1'b1;
      random_request(idx);
    end
    s_tvalid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ordered_list_engine_unit regression: pass");
    else
      $display("ordered_list_engine_unit regression: fail");
    $finish;
  end

endmodule
